FILE: rtl/indexed_sequence_store_defines.svh
// Assertion macros for the checker file.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define ISS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ISS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/iss_pkg.sv
package iss_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
    logic [7:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [8:0]         length;
    logic signed [31:0] mean;
  } rsp_t;

endpackage

FILE: rtl/iss_req_if.sv
interface iss_req_if;
  logic          valid;
  logic          ready;
  iss_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/iss_rsp_if.sv
interface iss_rsp_if;
  logic          valid;
  logic          ready;
  iss_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/indexed_sequence_store.sv
// Channel | Dir | Payload                                  | Transaction
// --------+-----+------------------------------------------+---------------------------
// req     | in  | operation, value, position               | valid & ready at clk edge
// rsp     | out | status, read_value, length, mean         | valid & ready at clk edge
//
// Sequencing: one request at a time. Insert and remove move one entry per cycle
// through the entry memory, then a restoring divider recomputes the mean; a
// removal that empties the store skips the divider.
// Reset: rst clears length, sum and mean; the memory is not cleared.
// Stalls: a result waits in the output register while the next request is taken;
// that request holds in its final step until the output register frees up.
module indexed_sequence_store #(
  parameter int CAPACITY = 256
) (
  input logic       clk,
  input logic       rst,
  iss_req_if.sink   req,
  iss_rsp_if.source rsp
);
  import iss_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int PW    = (CW > 8) ? CW : 8;
  localparam int SUM_W = 32 + CW;
  localparam int DCW   = $clog2(SUM_W + 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_UP_SHIFT = 4'd2;
  localparam logic [3:0] S_UP_LAST  = 4'd3;
  localparam logic [3:0] S_UP_FIN   = 4'd4;
  localparam logic [3:0] S_RM_TAKE  = 4'd5;
  localparam logic [3:0] S_DN_SHIFT = 4'd6;
  localparam logic [3:0] S_DN_LAST  = 4'd7;
  localparam logic [3:0] S_GET_WAIT = 4'd8;
  localparam logic [3:0] S_DIV_INIT = 4'd9;
  localparam logic [3:0] S_DIV_RUN  = 4'd10;
  localparam logic [3:0] S_DIV_END  = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  logic [3:0] state;

  // Entry memory: one write and one registered read per cycle.
  logic [31:0] mem [CAPACITY];
  logic [31:0] rdata;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_wdata;

  // Request held for the duration of the operation.
  logic [1:0]         op;
  logic signed [31:0] val;
  logic [7:0]         pos;

  // Architectural state.
  logic [CW-1:0]           count;
  logic signed [SUM_W-1:0] sum;
  logic signed [31:0]      mean_q;

  // Shift walker: idx is the next entry to read, mv_dst where the last read lands.
  logic [CW-1:0] idx;
  logic          mv_pend;
  logic [AW-1:0] mv_dst;

  // Divider.
  logic [SUM_W-1:0] dq;
  logic [CW-1:0]    rem;
  logic             neg;
  logic [DCW-1:0]   dcnt;
  logic [CW:0]      shifted;

  // Result.
  logic [1:0]  status;
  logic [31:0] read_val;
  logic        out_vld;
  rsp_t        out_q;

  logic [PW-1:0] pos_w;
  logic [PW-1:0] cnt_w;
  logic [AW-1:0] pos_a;
  logic          full;
  logic          ins_ok;
  logic          rd_ok;
  logic          out_free;

  assign pos_w    = PW'(pos);
  assign cnt_w    = PW'(count);
  assign pos_a    = AW'(pos_w);
  assign full     = (count == CW'(CAPACITY));
  assign ins_ok   = !full && (pos_w <= cnt_w);
  assign rd_ok    = (pos_w < cnt_w);
  assign out_free = !out_vld || rsp.ready;
  assign shifted  = {rem, dq[SUM_W-1]};

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_vld;
  assign rsp.payload = out_q;

  // Memory port control per sequencer step.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = '0;
    mem_raddr = '0;
    mem_wdata = '0;
    unique case (state)
      S_CHECK: begin
        if ((op == OP_GET || op == OP_REMOVE) && rd_ok) begin
          mem_re    = 1'b1;
          mem_raddr = pos_a;
        end
        // Append needs no shift: write straight away.
        if (op == OP_INSERT && ins_ok && pos_w == cnt_w) begin
          mem_we    = 1'b1;
          mem_waddr = pos_a;
          mem_wdata = val;
        end
      end
      S_UP_SHIFT, S_DN_SHIFT: begin
        mem_re    = 1'b1;
        mem_raddr = idx[AW-1:0];
        mem_we    = mv_pend;
        mem_waddr = mv_dst;
        mem_wdata = rdata;
      end
      S_UP_LAST, S_DN_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = mv_dst;
        mem_wdata = rdata;
      end
      S_UP_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = pos_a;
        mem_wdata = val;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      sum     <= '0;
      mean_q  <= '0;
      mv_pend <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      // Drop the result once the sink takes it, unless the next one loads below.
      if (out_vld && rsp.ready && state != S_DONE) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.payload.operation;
            val   <= req.payload.value;
            pos   <= req.payload.position;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          read_val <= '0;
          mv_pend  <= 1'b0;
          priority if (op == OP_INSERT) begin
            if (full) begin
              status <= ST_FULL;
              state  <= S_DONE;
            end else if (!ins_ok) begin
              status <= ST_BAD;
              state  <= S_DONE;
            end else if (pos_w == cnt_w) begin
              status <= ST_OK;
              count  <= count + CW'(1);
              sum    <= sum + {{(SUM_W-32){val[31]}}, val};
              state  <= S_DIV_INIT;
            end else begin
              status <= ST_OK;
              idx    <= count - CW'(1);
              state  <= S_UP_SHIFT;
            end
          end else if (op == OP_GET || op == OP_REMOVE) begin
            if (!rd_ok) begin
              status <= ST_BAD;
              state  <= S_DONE;
            end else if (op == OP_GET) begin
              status <= ST_OK;
              state  <= S_GET_WAIT;
            end else begin
              status <= ST_OK;
              idx    <= CW'(pos_w) + CW'(1);
              state  <= S_RM_TAKE;
            end
          end else begin
            status <= ST_BAD;
            state  <= S_DONE;
          end
        end
        S_UP_SHIFT: begin
          // Walk down from the last entry, each one landing one place higher.
          mv_pend <= 1'b1;
          mv_dst  <= idx[AW-1:0] + AW'(1);
          if (PW'(idx) == pos_w) begin
            state <= S_UP_LAST;
          end else begin
            idx <= idx - CW'(1);
          end
        end
        S_UP_LAST: begin
          mv_pend <= 1'b0;
          state   <= S_UP_FIN;
        end
        S_UP_FIN: begin
          count <= count + CW'(1);
          sum   <= sum + {{(SUM_W-32){val[31]}}, val};
          state <= S_DIV_INIT;
        end
        S_RM_TAKE: begin
          sum <= sum - {{(SUM_W-32){rdata[31]}}, rdata};
          if (idx == count) begin
            count <= count - CW'(1);
            state <= S_DIV_INIT;
          end else begin
            state <= S_DN_SHIFT;
          end
        end
        S_DN_SHIFT: begin
          // Walk up past the removed entry, each one landing one place lower.
          mv_pend <= 1'b1;
          mv_dst  <= idx[AW-1:0] - AW'(1);
          if (idx == count - CW'(1)) begin
            state <= S_DN_LAST;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_DN_LAST: begin
          mv_pend <= 1'b0;
          count   <= count - CW'(1);
          state   <= S_DIV_INIT;
        end
        S_GET_WAIT: begin
          read_val <= rdata;
          state    <= S_DONE;
        end
        S_DIV_INIT: begin
          if (count == '0) begin
            mean_q <= '0;
            state  <= S_DONE;
          end else begin
            neg   <= sum[SUM_W-1];
            dq    <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
            rem   <= '0;
            dcnt  <= '0;
            state <= S_DIV_RUN;
          end
        end
        S_DIV_RUN: begin
          // One quotient bit per cycle, restoring.
          if (shifted >= {1'b0, count}) begin
            rem <= CW'(shifted - {1'b0, count});
            dq  <= {dq[SUM_W-2:0], 1'b1};
          end else begin
            rem <= shifted[CW-1:0];
            dq  <= {dq[SUM_W-2:0], 1'b0};
          end
          if (dcnt == DCW'(SUM_W - 1)) begin
            state <= S_DIV_END;
          end else begin
            dcnt <= dcnt + DCW'(1);
          end
        end
        S_DIV_END: begin
          mean_q <= neg ? -(dq[31:0]) : dq[31:0];
          state  <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register frees up.
          if (out_free) begin
            out_q.status     <= status;
            out_q.read_value <= read_val;
            out_q.length     <= 9'(count);
            out_q.mean       <= mean_q;
            out_vld          <= 1'b1;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/iss_checker.sv
`include "indexed_sequence_store_defines.svh"

module iss_checker #(
  parameter int CAPACITY = 256
) (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input iss_pkg::rsp_t      rsp_payload
);
  import iss_pkg::*;

  // One request at a time: the block is busy the cycle after a take.
  `ISS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

  `ISS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "result changed while stalled")

  `ISS_ASSERT_NOW(a_err_no_value, rsp_valid && rsp_payload.status != ST_OK, rsp_payload.read_value == '0, "failed request returned a value")

  `ISS_ASSERT_NOW(a_empty_mean, rsp_valid && rsp_payload.length == '0, rsp_payload.mean == '0, "empty store with nonzero mean")

  `ISS_ASSERT_NOW(a_full_length, rsp_valid && rsp_payload.status == ST_FULL, rsp_payload.length == 9'(CAPACITY), "full status below capacity")

endmodule

bind indexed_sequence_store iss_checker #(.CAPACITY(CAPACITY)) u_iss_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
  import iss_pkg::*;

  // Store size of the instance under test; positions reach only 255, so the
  // last slot is filled by an append at position 255.
  localparam int SEQ_CAP = 256;
  // Code the block has no operation for; it must come back as a bad request.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Give the slowest request, stalls and gaps plenty of room.
  localparam int RUN_LIMIT = 2_000_000;
  localparam int SETTLE_CYCLES = 400;

  logic clk = 1'b0;
  logic rst;

  iss_req_if req_ch ();
  iss_rsp_if rsp_ch ();

  indexed_sequence_store #(
    .CAPACITY(SEQ_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the store. It advances once per accepted request transaction
  // and yields the result that the block must return for that request.
  // ---------------------------------------------------------------------------
  logic signed [31:0] seq_entries [SEQ_CAP];
  int                 seq_len = 0;
  longint             seq_sum = 0;

  function automatic rsp_t apply_request(req_t rq);
    rsp_t   r;
    int     p;
    int     i;
    longint quot;
    r = '0;
    r.status = ST_OK;
    p = rq.position;
    case (rq.operation)
      OP_INSERT: begin
        // A full store is reported before the position is looked at.
        if (seq_len >= SEQ_CAP) begin
          r.status = ST_FULL;
        end else if (p > seq_len) begin
          r.status = ST_BAD;
        end else begin
          for (i = seq_len; i > p; i--) seq_entries[i] = seq_entries[i - 1];
          seq_entries[p] = rq.value;
          seq_len++;
          seq_sum += rq.value;
        end
      end
      OP_GET: begin
        if (p >= seq_len) r.status = ST_BAD;
        else r.read_value = seq_entries[p];
      end
      OP_REMOVE: begin
        // A position equal to the length is an error, not a removal.
        if (p >= seq_len) begin
          r.status = ST_BAD;
        end else begin
          seq_sum -= seq_entries[p];
          for (i = p; i < seq_len - 1; i++) seq_entries[i] = seq_entries[i + 1];
          seq_len--;
        end
      end
      default: r.status = ST_BAD;
    endcase
    r.length = seq_len[8:0];
    // Integer division of signed operands truncates toward zero.
    quot = (seq_len == 0) ? 64'sd0 : seq_sum / longint'(seq_len);
    r.mean = quot[31:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation. A length tracker follows the store at generation time
  // so that most requests hit valid positions and reach the shifting paths.
  // ---------------------------------------------------------------------------
  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   gen_len = 0;

  function automatic void queue_request(logic [1:0] op, logic signed [31:0] val,
                                        logic [7:0] pos);
    req_t rq;
    rq.operation = op;
    rq.value = val;
    rq.position = pos;
    pending_reqs.push_back(rq);
    if (op == OP_INSERT && gen_len < SEQ_CAP && int'(pos) <= gen_len) gen_len++;
    else if (op == OP_REMOVE && int'(pos) < gen_len) gen_len--;
  endfunction

  // Mix extremes and small magnitudes in with full-range values so that sums
  // of mixed sign and the truncation of the mean both get exercised.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return int'($urandom_range(20)) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Short request sequences with the store kept small, so that shifts and the
  // mean update stay cheap. A slice of noise covers the unused code and wild
  // positions; a few requests sit exactly one past the end.
  task automatic mix_small(int n);
    int         r;
    int         ins_pct;
    logic [1:0] op;
    int         pos;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 8) begin
        queue_request(2'($urandom_range(3)), $urandom, 8'($urandom_range(255)));
      end else begin
        ins_pct = (gen_len < 3) ? 70 : ((gen_len > 20) ? 25 : 45);
        r = $urandom_range(99);
        if (gen_len == 0 || r < ins_pct) op = OP_INSERT;
        else if (r < ins_pct + (100 - ins_pct) / 2) op = OP_GET;
        else op = OP_REMOVE;
        if ($urandom_range(19) == 0) pos = gen_len + ((op == OP_INSERT) ? 1 : 0);
        else if (op == OP_INSERT) pos = $urandom_range(gen_len);
        else pos = $urandom_range(gen_len - 1);
        queue_request(op, pick_value(), 8'(pos));
      end
    end
  endtask

  // Grow the store to full capacity, poke at the full store, then empty it.
  // Appends and removals at the tail are cheap; only a few land deep inside.
  task automatic fill_and_drain();
    int pos;
    while (gen_len < SEQ_CAP) begin
      pos = ($urandom_range(29) == 0) ? $urandom_range(gen_len) : gen_len;
      queue_request(OP_INSERT, pick_value(), 8'(pos));
    end
    repeat (6) queue_request(OP_INSERT, pick_value(), 8'($urandom_range(255)));
    queue_request(OP_INSERT, pick_value(), 8'd255);
    repeat (12) queue_request(OP_GET, $urandom, 8'($urandom_range(255)));
    queue_request(OP_GET, 32'sd0, 8'd0);
    queue_request(OP_GET, 32'sd0, 8'd255);
    // Free the last slot and refill it, then do the same at the head.
    queue_request(OP_REMOVE, 32'sd0, 8'd255);
    queue_request(OP_INSERT, pick_value(), 8'd255);
    queue_request(OP_REMOVE, 32'sd0, 8'd0);
    queue_request(OP_INSERT, pick_value(), 8'd0);
    repeat (3) queue_request(OP_UNUSED, $urandom, 8'($urandom_range(255)));
    while (gen_len > 0) begin
      if ($urandom_range(9) == 0)
        queue_request(OP_GET, $urandom, 8'($urandom_range(gen_len - 1)));
      pos = ($urandom_range(29) == 0) ? $urandom_range(gen_len - 1) : gen_len - 1;
      queue_request(OP_REMOVE, $urandom, 8'(pos));
    end
  endtask

  // Hand-picked opening sequence, starting from an empty store.
  task automatic queue_directed();
    // Requests on an empty store, an insert past the end, the unused code.
    queue_request(OP_GET, 32'sd0, 8'd0);
    queue_request(OP_REMOVE, 32'sd0, 8'd0);
    queue_request(OP_INSERT, 32'sd5, 8'd1);
    queue_request(OP_UNUSED, 32'sd0, 8'd0);
    // Build {min, min, -1, max, max}: head, tail and middle inserts; the mean
    // of -3 over 5 entries truncates to zero.
    queue_request(OP_INSERT, 32'sh7fff_ffff, 8'd0);
    queue_request(OP_INSERT, 32'sh7fff_ffff, 8'd1);
    queue_request(OP_INSERT, 32'sh8000_0000, 8'd0);
    queue_request(OP_INSERT, 32'sh8000_0000, 8'd0);
    queue_request(OP_INSERT, -32'sd1, 8'd2);
    // Reads at both ends, then requests exactly at and far past the end.
    queue_request(OP_GET, 32'sd0, 8'd0);
    queue_request(OP_GET, 32'sd0, 8'd4);
    queue_request(OP_GET, 32'sd0, 8'd5);
    queue_request(OP_REMOVE, 32'sd0, 8'd5);
    queue_request(OP_INSERT, 32'sd1, 8'd255);
    queue_request(OP_GET, 32'sd0, 8'd255);
    // Remove from the middle, the head and the tail until empty.
    queue_request(OP_REMOVE, 32'sd0, 8'd2);
    queue_request(OP_REMOVE, 32'sd0, 8'd0);
    queue_request(OP_REMOVE, 32'sd0, 8'd2);
    queue_request(OP_REMOVE, 32'sd0, 8'd1);
    queue_request(OP_REMOVE, 32'sd0, 8'd0);
    // A sum of -5 over 2 entries must give -2, not the floor of -3.
    queue_request(OP_INSERT, -32'sd7, 8'd0);
    queue_request(OP_INSERT, 32'sd2, 8'd1);
    queue_request(OP_UNUSED, 32'shffff_ffff, 8'd255);
    queue_request(OP_REMOVE, 32'sd0, 8'd0);
    queue_request(OP_REMOVE, 32'sd0, 8'd0);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge. A transaction counts at
  // the rising edge with valid and ready high; hold the item until then.
  // ---------------------------------------------------------------------------
  int unsigned send_idle_pct = 8;
  int unsigned recv_idle_pct = 55;
  int unsigned offered_n = 0;
  int unsigned accepted_n = 0;
  int          err_n = 0;
  int          cycle_n = 0;

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (offered_n == accepted_n) begin
      // Previous item is gone: offer the next one unless this cycle idles.
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.payload <= pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        offered_n++;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Record each accepted request and predict its result right away.
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      expected_rsps.push_back(apply_request(req_ch.payload));
      accepted_n++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: match each result transaction against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_result(rsp_t got);
    rsp_t want;
    if (expected_rsps.size() == 0) begin
      $display("%0t: result with no request pending: status %0d value %0d len %0d mean %0d",
               $time, got.status, got.read_value, got.length, got.mean);
      err_n++;
      return;
    end
    want = expected_rsps.pop_front();
    if (got.status !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      err_n++;
    end
    if (got.read_value !== want.read_value) begin
      $display("%0t: read_value expected %0d actual %0d", $time,
               want.read_value, got.read_value);
      err_n++;
    end
    if (got.length !== want.length) begin
      $display("%0t: length expected %0d actual %0d", $time, want.length, got.length);
      err_n++;
    end
    if (got.mean !== want.mean) begin
      $display("%0t: mean expected %0d actual %0d", $time, want.mean, got.mean);
      err_n++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) check_result(rsp_ch.payload);
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n > RUN_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing: reset once, then three phases with different idle patterns.
  // ---------------------------------------------------------------------------
  task automatic drain_all();
    while (pending_reqs.size() != 0 || offered_n != accepted_n ||
           expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;

    // Phase one: sender mostly busy, receiver stalls often. Carries the
    // directed opening and the full-store excursion.
    queue_directed();
    mix_small(380);
    fill_and_drain();
    mix_small(40);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    drain_all();

    // Phase two: swap the roles; long input gaps, eager receiver.
    send_idle_pct = 55;
    recv_idle_pct = 8;
    mix_small(380);
    drain_all();

    // Phase three: back-to-back traffic on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mix_small(380);
    drain_all();

    // Let any stray result show up before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_n == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
